FILE: rtl/core/fcnlp_pkg.sv
// ----------------------------------------------------------------------------
// fcnlp_pkg
// Shared types, constants and address helpers for the dual FIFO cache core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcnlp_pkg;

	localparam int NSETS   = 256;
	localparam int NWAYS   = 8;
	localparam int ABITS   = 48;
	localparam int SET_W   = 8;
	localparam int WAY_W   = 3;
	localparam int CNT_W   = 32;
	localparam int NCNT    = 8;
	localparam int CFG_W   = 4;

	// Clamp limits of the geometry registers
	localparam logic [CFG_W-1:0] OFF_MAX  = 4'd12;
	localparam logic [CFG_W-1:0] SIDX_MAX = 4'd8;
	localparam logic [CFG_W-1:0] WAYS_MAX = 4'd8;

	// Register indexes (word address bits [3:2])
	localparam logic [1:0] REG_BLOCK_OFF = 2'd0;
	localparam logic [1:0] REG_SET_IDX   = 2'd1;
	localparam logic [1:0] REG_WAYS      = 2'd2;

	// Event counter indexes, per cache base
	localparam int CNT_RD   = 0;
	localparam int CNT_WR   = 1;
	localparam int CNT_HIT  = 2;
	localparam int CNT_MISS = 3;
	localparam int PF_BASE  = 4;

	typedef logic [ABITS-1:0] addr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// One memory row holds a whole set
	typedef struct packed {
		logic [NWAYS-1:0]            vld;
		logic [WAY_W-1:0]            ptr;
		logic [NWAYS-1:0][ABITS-1:0] tag;
	} row_t;

	typedef struct packed {
		logic hit;
		row_t row;
	} look_t;

	function automatic logic [SET_W-1:0] blk_set(addr_t a, logic [CFG_W-1:0] off,
		logic [CFG_W-1:0] sb);
		addr_t blk;
		logic [SET_W:0] msk;
		blk = a >> off;
		msk = (9'd1 << sb) - 9'd1;
		return blk[SET_W-1:0] & msk[SET_W-1:0];
	endfunction

	function automatic addr_t blk_tag(addr_t a, logic [CFG_W-1:0] off,
		logic [CFG_W-1:0] sb);
		return (a >> off) >> sb;
	endfunction

	// Search the set; on a miss fill the FIFO victim way
	function automatic look_t row_lookup(row_t r, addr_t tg, logic [CFG_W-1:0] ways);
		look_t res;
		logic [WAY_W-1:0] p;
		logic [CFG_W-1:0] p1;
		res.hit = 1'b0;
		res.row = r;
		for (int w = 0; w < NWAYS; w++) begin
			if (CFG_W'(w) < ways && r.vld[w] && r.tag[w] == tg)
				res.hit = 1'b1;
		end
		p = ({1'b0, r.ptr} >= ways) ? '0 : r.ptr;
		p1 = {1'b0, p} + 4'd1;
		res.row.tag[p] = tg;
		res.row.vld[p] = 1'b1;
		res.row.ptr = (p1 == ways) ? '0 : p1[WAY_W-1:0];
		return res;
	endfunction

	function automatic cnt_t sat_inc(cnt_t v, logic en);
		return (en && v != '1) ? v + cnt_t'(1) : v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fifo_cache_with_next_line_prefetch_core.sv
// ----------------------------------------------------------------------------
// fifo_cache_with_next_line_prefetch_core
// Two write-through set-associative FIFO caches, the second with next-line
// prefetch, fed by one access stream; reports hits and event counters.
// ----------------------------------------------------------------------------
// Each access goes from accept through a lookup of both caches to the result. When
// the prefetching cache misses, a second read-modify-write pass of its tag memory
// for the next block follows, and the result may wait for m_tready. Both
// tag memories are 256 rows of one set each, read through a register; a
// row valid bit per set, cleared by reset, stands for an empty set, so no
// clearing pass is needed. The next access is taken once the result sits in
// the output register.
`default_nettype none

module fifo_cache_with_next_line_prefetch_core
	import fcnlp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// access stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [55:0]  s_tdata,  // address[47:0], action[48], zero fill
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [263:0]      m_tdata   // plain_hit[0], prefetch_cache_hit[1],
	                                    // prefetch_issued[2], plain_mem_reads,
	                                    // plain_mem_writes, plain_hits,
	                                    // plain_misses, pf_mem_reads,
	                                    // pf_mem_writes, pf_hits, pf_misses
	                                    // (32 bits each from bit 3)
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LK1  = 3'd1;
	localparam logic [2:0] ST_PRD  = 3'd2;
	localparam logic [2:0] ST_LK2  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] boff_q, sidx_q, ways_q;
	logic [CFG_W-1:0] off_e, sb_e, ways_e;
	addr_t            addr_q, next_q, lk_addr, rd_addr;
	logic             wr_q, phit_q, fhit_q, issued_q;
	cnt_t             cnt_q [NCNT];
	logic             m_tvalid_q;
	logic [263:0]     m_tdata_q;

	row_t             pmem [NSETS];
	row_t             fmem [NSETS];
	logic [NSETS-1:0] prv_q, frv_q;
	row_t             prow_s1, frow_s1, prow, frow;
	logic             prv_s1, frv_s1;
	logic [SET_W-1:0] rd_set, lk_set;
	addr_t            lk_tag;
	look_t            plook, flook;
	logic             accept, cfg_wr;

	// Clamp the geometry
	always_comb begin
		off_e  = (boff_q > OFF_MAX) ? OFF_MAX : boff_q;
		sb_e   = (sidx_q > SIDX_MAX) ? SIDX_MAX : sidx_q;
		ways_e = (ways_q == '0) ? 4'd1 : ((ways_q > WAYS_MAX) ? WAYS_MAX : ways_q);
	end

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boff_q <= 4'd6;
			sidx_q <= 4'd4;
			ways_q <= 4'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BLOCK_OFF: boff_q <= pwdata[CFG_W-1:0];
				REG_SET_IDX:   sidx_q <= pwdata[CFG_W-1:0];
				REG_WAYS:      ways_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BLOCK_OFF: prdata = 32'(boff_q);
			REG_SET_IDX:   prdata = 32'(sidx_q);
			REG_WAYS:      prdata = 32'(ways_q);
			default:       prdata = '0;
		endcase
	end

	// Memory read address: new access in idle, next block in prefetch read
	assign accept  = s_tvalid && s_tready;
	assign rd_addr = (state_q == ST_PRD) ? next_q : s_tdata[ABITS-1:0];
	assign rd_set  = blk_set(rd_addr, off_e, sb_e);

	always_ff @(posedge clk) begin
		prow_s1 <= pmem[rd_set];
		frow_s1 <= fmem[rd_set];
		prv_s1  <= prv_q[rd_set];
		frv_s1  <= frv_q[rd_set];
	end

	// An empty set reads as all zero
	assign prow = prv_s1 ? prow_s1 : '0;
	assign frow = frv_s1 ? frow_s1 : '0;

	// Lookup of the access address in both caches, or of the next block in the second pass
	assign lk_addr = (state_q == ST_LK2) ? next_q : addr_q;
	assign lk_set  = blk_set(lk_addr, off_e, sb_e);
	assign lk_tag  = blk_tag(lk_addr, off_e, sb_e);
	assign plook   = row_lookup(prow, lk_tag, ways_e);
	assign flook   = row_lookup(frow, lk_tag, ways_e);

	// Write back filled rows on a miss
	always_ff @(posedge clk) begin
		if (state_q == ST_LK1 && !plook.hit)
			pmem[lk_set] <= plook.row;
		if ((state_q == ST_LK1 || state_q == ST_LK2) && !flook.hit)
			fmem[lk_set] <= flook.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prv_q <= '0;
			frv_q <= '0;
		end else begin
			if (state_q == ST_LK1 && !plook.hit)
				prv_q[lk_set] <= 1'b1;
			if ((state_q == ST_LK1 || state_q == ST_LK2) && !flook.hit)
				frv_q[lk_set] <= 1'b1;
		end
	end

	// Access sequencer and event counters
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			issued_q   <= 1'b0;
			phit_q     <= 1'b0;
			fhit_q     <= 1'b0;
			for (int i = 0; i < NCNT; i++)
				cnt_q[i] <= '0;
		end else begin
			// Load a new result beat or drop the one taken
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issued_q <= 1'b0;
						state_q  <= ST_LK1;
					end
				end
				ST_LK1: begin
					phit_q <= plook.hit;
					fhit_q <= flook.hit;
					cnt_q[CNT_RD]   <= sat_inc(cnt_q[CNT_RD], !plook.hit);
					cnt_q[CNT_WR]   <= sat_inc(cnt_q[CNT_WR], wr_q);
					cnt_q[CNT_HIT]  <= sat_inc(cnt_q[CNT_HIT], plook.hit);
					cnt_q[CNT_MISS] <= sat_inc(cnt_q[CNT_MISS], !plook.hit);
					cnt_q[PF_BASE+CNT_RD]   <= sat_inc(cnt_q[PF_BASE+CNT_RD], !flook.hit);
					cnt_q[PF_BASE+CNT_WR]   <= sat_inc(cnt_q[PF_BASE+CNT_WR], wr_q);
					cnt_q[PF_BASE+CNT_HIT]  <= sat_inc(cnt_q[PF_BASE+CNT_HIT], flook.hit);
					cnt_q[PF_BASE+CNT_MISS] <= sat_inc(cnt_q[PF_BASE+CNT_MISS], !flook.hit);
					state_q <= flook.hit ? ST_OUT : ST_PRD;
				end
				ST_PRD: state_q <= ST_LK2;
				ST_LK2: begin
					issued_q <= !flook.hit;
					cnt_q[PF_BASE+CNT_RD] <= sat_inc(cnt_q[PF_BASE+CNT_RD], !flook.hit);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= s_tdata[ABITS-1:0];
			wr_q   <= s_tdata[ABITS];
		end
		if (state_q == ST_LK1)
			next_q <= addr_q + (addr_t'(1) << off_e);
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
			m_tdata_q <= {5'b0, cnt_q[7], cnt_q[6], cnt_q[5], cnt_q[4],
				cnt_q[3], cnt_q[2], cnt_q[1], cnt_q[0], issued_q, fhit_q, phit_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/fcnlp_checker.sv
// ----------------------------------------------------------------------------
// fcnlp_checker
// Port-level checks of the cache core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fcnlp_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [263:0] m_tdata
);

	logic beat;
	assign beat = m_tvalid && m_tready;

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A prefetch only follows a miss in the prefetching cache
	a_pf_miss: assert property (@(posedge clk) disable iff (!arst_n)
		beat && m_tdata[2] |-> !m_tdata[1] && m_tdata[258:227] != '0)
		else $error("prefetch without a miss");

	// A plain hit is reflected in the plain hit counter
	a_phit: assert property (@(posedge clk) disable iff (!arst_n)
		beat && m_tdata[0] |-> m_tdata[98:67] != '0)
		else $error("plain hit not counted");

	// A prefetching cache miss implies at least one memory read
	a_fmiss: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !m_tdata[1] |-> m_tdata[162:131] != '0)
		else $error("prefetching miss without a read");

endmodule

bind fifo_cache_with_next_line_prefetch_core fcnlp_checker u_fcnlp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
